// File: rtl/core/jsh_pkg.sv
// ----------------------------------------------------------------------------
// jsh_pkg
// Shared constants and types for the symbol histogram unit.
// ----------------------------------------------------------------------------
package jsh_pkg;

  // block geometry and counter width
  localparam int unsigned BLOCK_COEFFS = 64;
  localparam int unsigned COUNT_BITS   = 32;

  // coefficient position / zero run width, and width of a ZRL batch increment
  localparam int unsigned POS_W = $clog2(BLOCK_COEFFS);
  localparam int unsigned INC_W = $clog2(BLOCK_COEFFS / 16 + 2);

  // counter store: four tables of 256 bins
  localparam int unsigned TABLE_BINS = 256;
  localparam int unsigned MEM_DEPTH  = 4 * TABLE_BINS;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);

  // special symbols and bins
  localparam logic [7:0] SYM_ZRL          = 8'hF0;
  localparam logic [7:0] SYM_EOB          = 8'h00;
  localparam logic [8:0] READ_BIN_RESERVED = 9'd256;

  // item kinds
  localparam logic KIND_COEF = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // one pending counter update
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [INC_W-1:0]  inc;
  } upd_op_t;

endpackage

// File: rtl/core/jsh_if.sv
// ----------------------------------------------------------------------------
// jsh_if
// Valid/ready channels of the symbol histogram unit.
// ----------------------------------------------------------------------------
interface jsh_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               component;
  logic signed [15:0] coefficient;
  logic               read_ac;
  logic        [8:0]  read_bin;

  modport source (output valid, kind, component, coefficient, read_ac, read_bin,
                  input ready);
  modport sink   (input valid, kind, component, coefficient, read_ac, read_bin,
                  output ready);
endinterface

interface jsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;

  modport source (output valid, count, input ready);
  modport sink   (input valid, count, output ready);
endinterface

// File: rtl/core/jsh_size_class.sv
// ----------------------------------------------------------------------------
// jsh_size_class
// Size class of a 16-bit two's complement coefficient (bits of magnitude).
// ----------------------------------------------------------------------------
module jsh_size_class import jsh_pkg::*; (
  input  logic signed [15:0] coefficient_i,
  output logic        [4:0]  size_o
);

  logic [16:0] ext;
  logic [16:0] mag;

  // magnitude, 17 bits so that the most negative value stays exact
  assign ext = {coefficient_i[15], coefficient_i};
  assign mag = coefficient_i[15] ? (~ext + 17'd1) : ext;

  // position of the highest set bit, plus one
  always_comb begin
    size_o = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) begin
        size_o = 5'(i + 1);
      end
    end
  end

endmodule

// File: rtl/core/jpeg_symbol_histogram_unit.sv
// ----------------------------------------------------------------------------
// jpeg_symbol_histogram_unit
// Huffman symbol frequency counter: four saturating tables in one RAM.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its 1024-entry counter RAM to zero, one entry a
// cycle, and accepts no transaction until the sweep is done. Afterwards it
// handles one item at a time. A coefficient item is accepted and then costs
// one RAM read and one saturating write back per counter update (through the
// single read/write port pair): zero updates for a plain zero, one for a DC
// class, an EOB or a short-run symbol, two for a ZRL batch followed by its
// symbol. A read item is accepted, then read from the RAM, then placed in the
// result register; it waits while a previous result is still held on the
// output.
// ----------------------------------------------------------------------------
module jpeg_symbol_histogram_unit import jsh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsh_in_if.sink    in_i,
  jsh_out_if.source out_o
);

  // sequencer states
  localparam logic [2:0] ST_CLR     = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RD_REQ  = 3'd2;
  localparam logic [2:0] ST_RD_DATA = 3'd3;
  localparam logic [2:0] ST_UPD_RD  = 3'd4;
  localparam logic [2:0] ST_UPD_WR  = 3'd5;

  localparam int unsigned WIDE_W = COUNT_BITS + 32;

  logic [2:0]            state_q, state_d;
  logic [ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [POS_W-1:0]      zr_q, zr_d;
  upd_op_t               op0_q, op0_d, op1_q, op1_d;
  logic                  rd_comp_q, rd_ac_q;
  logic [8:0]            rd_bin_q;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_count_q, out_count_d;

  logic                  in_acc;
  logic [4:0]            cls;
  logic [3:0]            ac_sz;
  logic                  last;
  logic [7:0]            ac_sym;
  upd_op_t               nxt0, nxt1;
  logic [POS_W-1:0]      nxt_zr;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata_q;
  logic [COUNT_BITS:0]   sum;
  logic [WIDE_W-1:0]     wide;

  logic [COUNT_BITS-1:0] mem [MEM_DEPTH];

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.count = out_count_q;

  jsh_size_class u_size_class (
    .coefficient_i (in_i.coefficient),
    .size_o        (cls)
  );

  // run-length coding of the incoming coefficient
  assign last   = (pos_q == POS_W'(BLOCK_COEFFS - 1));
  assign ac_sz  = (cls > 5'd15) ? 4'd15 : cls[3:0];
  assign ac_sym = {4'(zr_q % 16), ac_sz};

  always_comb begin
    nxt0   = '0;
    nxt1   = '0;
    nxt_zr = '0;
    if (pos_q == '0) begin
      nxt0 = '{vld: 1'b1, addr: {in_i.component, 1'b0, 3'b000, cls}, inc: INC_W'(1)};
    end else if (in_i.coefficient == 16'sd0) begin
      nxt_zr = last ? '0 : zr_q + POS_W'(1);
      if (last) begin
        nxt0 = '{vld: 1'b1, addr: {in_i.component, 1'b1, SYM_EOB}, inc: INC_W'(1)};
      end
    end else if (zr_q >= 16) begin
      nxt0 = '{vld: 1'b1, addr: {in_i.component, 1'b1, SYM_ZRL}, inc: INC_W'(zr_q >> 4)};
      nxt1 = '{vld: 1'b1, addr: {in_i.component, 1'b1, ac_sym}, inc: INC_W'(1)};
    end else begin
      nxt0 = '{vld: 1'b1, addr: {in_i.component, 1'b1, ac_sym}, inc: INC_W'(1)};
    end
  end

  // saturating increment of the counter just read
  assign sum       = {1'b0, mem_rdata_q} + (COUNT_BITS + 1)'(op0_q.inc);
  assign wide      = WIDE_W'(mem_rdata_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    pos_d       = pos_q;
    zr_d        = zr_q;
    op0_d       = op0_q;
    op1_d       = op1_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    mem_we      = 1'b0;
    mem_waddr   = op0_q.addr;
    mem_wdata   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    mem_raddr   = op0_q.addr;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == KIND_READ) begin
            state_d = ST_RD_REQ;
          end else begin
            pos_d   = last ? '0 : pos_q + POS_W'(1);
            zr_d    = nxt_zr;
            op0_d   = nxt0;
            op1_d   = nxt1;
            state_d = nxt0.vld ? ST_UPD_RD : ST_IDLE;
          end
        end
      end
      ST_RD_REQ: begin
        mem_raddr = {rd_comp_q, rd_ac_q, rd_bin_q[7:0]};
        if (!out_valid_q) begin
          state_d = ST_RD_DATA;
        end
      end
      ST_RD_DATA: begin
        out_valid_d = 1'b1;
        if (rd_bin_q == READ_BIN_RESERVED) begin
          out_count_d = 32'd1;
        end else if (rd_bin_q[8]) begin
          out_count_d = 32'd0;
        end else if (wide > WIDE_W'(32'hFFFF_FFFF)) begin
          out_count_d = 32'hFFFF_FFFF;
        end else begin
          out_count_d = wide[31:0];
        end
        state_d = ST_IDLE;
      end
      ST_UPD_RD: begin
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        op0_d     = op1_q;
        op1_d.vld = 1'b0;
        state_d   = op1_q.vld ? ST_UPD_RD : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      pos_q       <= '0;
      zr_q        <= '0;
      op0_q       <= '0;
      op1_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      pos_q       <= pos_d;
      zr_q        <= zr_d;
      op0_q       <= op0_d;
      op1_q       <= op1_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    if (in_acc) begin
      rd_comp_q <= in_i.component;
      rd_ac_q   <= in_i.read_ac;
      rd_bin_q  <= in_i.read_bin;
    end
  end

  // counter RAM, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // a write-back always follows its own read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR) |-> ($past(state_q) == ST_UPD_RD))
    else $error("write-back without a preceding read");

  // saturating update never lowers a counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_WR) |-> (mem_wdata >= mem_rdata_q))
    else $error("counter decreased on update");

  // the block position wraps after the last coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.kind == KIND_COEF && last) |=> (pos_q == '0 && zr_q == '0))
    else $error("block position did not wrap");

  // a result is only loaded once the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_DATA) |-> !out_valid_q)
    else $error("result overwrote a pending transaction");

endmodule
